### sv/sem_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and controller/datapath interface types for the Sobel block.
package sem_pkg;

	// Default size limits of the frame.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Channel and pixel widths.
	localparam int CH_W  = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W = CH_W * NUM_CH;

	// Configuration port.
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_ADDR_W   = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

	// Gradient and magnitude arithmetic.
	localparam int GRAD_W     = 11;
	localparam int SUM_W      = 21;
	localparam int SQ_W       = 20;
	localparam int ROOT_STEPS = CH_W;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	typedef struct packed {
		logic              take;
		logic              update;
		logic              grad;
		logic              sum;
		logic              step;
		logic [STEP_W-1:0] bit_idx;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic emit;
		logic out_busy;
	} sts_t;

endpackage

### sv/sem_mag.sv
`timescale 1ns / 1ps
// One channel's Sobel gradients, squared sum and bit-serial rounded square root.
module sem_mag (
	input  logic                               clk,
	input  sem_pkg::cmd_t                      cmd,
	input  logic [8:0][sem_pkg::CH_W-1:0]      pix,
	output logic [sem_pkg::CH_W-1:0]           mag
);

	logic [9:0] xp, xn, yp, yn;
	logic signed [sem_pkg::GRAD_W-1:0] gx_q, gy_q;
	logic signed [2*sem_pkg::GRAD_W-1:0] sqx, sqy;
	logic [sem_pkg::SUM_W-1:0] sum_q;
	logic [sem_pkg::CH_W-1:0] res_q, cand;
	logic [2*sem_pkg::CH_W-1:0] cand_sq;
	logic [sem_pkg::SUM_W-1:0] lhs;

	// Pixel index is row * 3 + column.
	assign xp = 10'(pix[2]) + 10'({pix[5], 1'b0}) + 10'(pix[8]);
	assign xn = 10'(pix[0]) + 10'({pix[3], 1'b0}) + 10'(pix[6]);
	assign yp = 10'(pix[6]) + 10'({pix[7], 1'b0}) + 10'(pix[8]);
	assign yn = 10'(pix[0]) + 10'({pix[1], 1'b0}) + 10'(pix[2]);

	assign sqx = gx_q * gx_q;
	assign sqy = gy_q * gy_q;

	// Result is the largest r with r*r - r + 1 <= sum, found one bit per step.
	assign cand    = res_q | (sem_pkg::CH_W'(1) << cmd.bit_idx);
	assign cand_sq = (2*sem_pkg::CH_W)'(cand) * (2*sem_pkg::CH_W)'(cand);
	assign lhs     = sem_pkg::SUM_W'(cand_sq) - sem_pkg::SUM_W'(cand) + sem_pkg::SUM_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gx_q <= $signed({1'b0, xp}) - $signed({1'b0, xn});
			gy_q <= $signed({1'b0, yp}) - $signed({1'b0, yn});
		end
		if (cmd.sum) begin
			sum_q <= {1'b0, sqx[sem_pkg::SQ_W-1:0]} + {1'b0, sqy[sem_pkg::SQ_W-1:0]};
			res_q <= '0;
		end else if (cmd.step) begin
			if (lhs <= sum_q) begin
				res_q <= cand;
			end
		end
	end

	assign mag = res_q;

endmodule

### sv/sem_dp.sv
`timescale 1ns / 1ps
// Datapath: size registers, stream position, line stores, window, magnitude units, output register.
module sem_dp #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sem_pkg::cmd_t                     cmd,
	output sem_pkg::sts_t                     sts,
	input  logic                              cfg_wr_en,
	input  logic [sem_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              s_tuser,
	input  logic [sem_pkg::PIX_W-1:0]         s_tdata,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [sem_pkg::PIX_W-1:0]         m_tdata,
	output logic                              m_tlast
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EWW = $clog2(MAX_WIDTH + 1);
	localparam int EHW = $clog2(MAX_HEIGHT + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int TW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	function automatic logic [EWW-1:0] clamp_w(input logic [sem_pkg::WIDTH_REG_W-1:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (x == 32'd0) begin
			x = 32'd1;
		end else if (x > 32'(MAX_WIDTH)) begin
			x = 32'(MAX_WIDTH);
		end
		return x[EWW-1:0];
	endfunction

	function automatic logic [EHW-1:0] clamp_h(input logic [sem_pkg::HEIGHT_REG_W-1:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (x == 32'd0) begin
			x = 32'd1;
		end else if (x > 32'(MAX_HEIGHT)) begin
			x = 32'(MAX_HEIGHT);
		end
		return x[EHW-1:0];
	endfunction

	logic [EWW-1:0] eff_w_q;
	logic [EHW-1:0] eff_h_q;
	logic [EWW+EHW-1:0] prod;
	logic [TW-1:0] total_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q, h_ext;
	logic [TW-1:0] cnt_q, cnt_inc;
	logic c0, r_lt_h, r_ge1, r_ge2, is_last_col, out_last, restart;

	logic [sem_pkg::PIX_W-1:0] ls0_mem [MAX_WIDTH];
	logic [sem_pkg::PIX_W-1:0] ls1_mem [MAX_WIDTH];
	logic [sem_pkg::PIX_W-1:0] rd0_s1, rd1_s1, pix_s1, top, mid;
	logic c0_s1, pre_s1, post_s1, top_ok_s1, mid_ok_s1;

	logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_q, ewin_q;
	logic [sem_pkg::NUM_CH-1:0][sem_pkg::CH_W-1:0] mag;
	logic out_valid_q;
	logic cfg_hit;

	assign h_ext  = RW'(eff_h_q);
	assign c0     = (col_q == '0);
	assign r_lt_h = (row_q < h_ext);
	assign r_ge1  = (row_q >= RW'(1));
	assign r_ge2  = (row_q >= RW'(2));
	assign is_last_col = ((EWW'(col_q) + EWW'(1)) == eff_w_q);
	assign prod    = (EWW+EHW)'(eff_w_q) * (EWW+EHW)'(eff_h_q);
	assign cnt_inc = cnt_q + TW'(1);
	assign out_last = (cnt_inc >= total_q);
	assign cfg_hit = cfg_wr_en &&
		((cfg_addr == sem_pkg::REG_IMAGE_WIDTH) || (cfg_addr == sem_pkg::REG_IMAGE_HEIGHT));
	assign restart = cfg_hit || (cmd.load_out && out_last);

	assign top = top_ok_s1 ? rd1_s1 : '0;
	assign mid = mid_ok_s1 ? rd0_s1 : '0;

	assign sts.skip     = r_lt_h && s_tuser;
	assign sts.emit     = pre_s1 || post_s1;
	assign sts.out_busy = out_valid_q && !m_tready;

	// Frame size is clamped once on write; total pixel count follows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= clamp_w(sem_pkg::WIDTH_RST);
			eff_h_q <= clamp_h(sem_pkg::HEIGHT_RST);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				sem_pkg::REG_IMAGE_WIDTH:  eff_w_q <= clamp_w(cfg_wdata[sem_pkg::WIDTH_REG_W-1:0]);
				sem_pkg::REG_IMAGE_HEIGHT: eff_h_q <= clamp_h(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		total_q <= prod[TW-1:0];
	end

	// Take captures store reads and item decode; update writes the line stores and edge window.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rd0_s1    <= ls0_mem[col_q];
			rd1_s1    <= ls1_mem[col_q];
			pix_s1    <= r_lt_h ? s_tdata : '0;
			c0_s1     <= c0;
			pre_s1    <= c0 && r_ge2;
			post_s1   <= !c0 && r_ge1 && (row_q <= h_ext);
			top_ok_s1 <= r_ge2 && (row_q <= h_ext + RW'(1));
			mid_ok_s1 <= r_ge1 && (row_q <= h_ext);
		end
		if (cmd.update) begin
			ls1_mem[col_q] <= rd0_s1;
			ls0_mem[col_q] <= pix_s1;
			if (c0_s1) begin
				for (int i = 0; i < 3; i++) begin
					ewin_q[i][0] <= win_q[i][1];
					ewin_q[i][1] <= win_q[i][2];
					ewin_q[i][2] <= '0;
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					ewin_q[i][0] <= win_q[i][1];
					ewin_q[i][1] <= win_q[i][2];
				end
				ewin_q[0][2] <= top;
				ewin_q[1][2] <= mid;
				ewin_q[2][2] <= pix_s1;
			end
		end
	end

	// Position, window and output count; restarted by a size write or the frame's last word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			win_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			win_q <= '0;
		end else begin
			if (cmd.update) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= c0_s1 ? '0 : win_q[i][1];
					win_q[i][1] <= c0_s1 ? '0 : win_q[i][2];
				end
				win_q[0][2] <= top;
				win_q[1][2] <= mid;
				win_q[2][2] <= pix_s1;
				if (is_last_col) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (cmd.load_out) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	for (genvar ch = 0; ch < sem_pkg::NUM_CH; ch++) begin : g_ch
		logic [8:0][sem_pkg::CH_W-1:0] pix;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pix[i*3+j] = ewin_q[i][j][ch*sem_pkg::CH_W +: sem_pkg::CH_W];
				end
			end
		end
		sem_mag u_mag (
			.clk (clk),
			.cmd (cmd),
			.pix (pix),
			.mag (mag[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= mag;
			m_tlast <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

### sv/sem_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences one item through the datapath.
module sem_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  sem_pkg::sts_t sts,
	output sem_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_GRAD,
		ST_SUM,
		ST_ROOT,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [sem_pkg::STEP_W-1:0] step_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.take     = s_tvalid && !sts.skip;
			ST_UPD:  cmd.update   = 1'b1;
			ST_GRAD: cmd.grad     = 1'b1;
			ST_SUM:  cmd.sum      = 1'b1;
			ST_ROOT: begin
				cmd.step    = 1'b1;
				cmd.bit_idx = step_q;
			end
			ST_OUT:  cmd.load_out = !sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (s_tvalid && !sts.skip) state_q <= ST_UPD;
				ST_UPD:  state_q <= sts.emit ? ST_GRAD : ST_IDLE;
				ST_GRAD: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_ROOT;
					step_q  <= sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1);
				end
				ST_ROOT: begin
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - sem_pkg::STEP_W'(1);
					end
				end
				ST_OUT:  if (!sts.out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/sobel_edge_magnitude_rgb_top.sv
`timescale 1ns / 1ps
// A word that completes an output pixel reaches m_tdata after take, update, gradient, squared sum,
// the 8-step square root and the output load; a word that completes no output pixel passes only
// through accept and line store update. Each channel has its own root unit; all step together.
// A finished word waits in the output register; the next input word is taken meanwhile.
// Reset (arst_n low, asynchronous) restores 640 x 480 and restarts the frame; line stores
// are not cleared, since only lines written in the current frame are ever read.
module sobel_edge_magnitude_rgb_top #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sem_pkg::PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
	input  logic                           s_tuser,   // op: 1 is a flush tick
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sem_pkg::PIX_W-1:0]      m_tdata,   // red_edge, green_edge, blue_edge
	output logic                           m_tlast,   // frame_end
	input  logic                           cfg_wr_en,
	input  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// The controller walks each accepted non-skipped word through take, update and, when a pixel
	// of the line above is complete, gradient, squared sum, square root and output load.
	sem_pkg::cmd_t cmd;
	sem_pkg::sts_t sts;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the two line stores, the 3x3 window and the three channel units.
	sem_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### sv/sem_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the Sobel block and its bind to the top level.
module sem_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [sem_pkg::PIX_W-1:0] m_tdata,
	input logic                      m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("pixel word did not occupy the block");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("output word appeared while the block was idle");

endmodule

bind sobel_edge_magnitude_rgb_top sem_chk u_sem_chk (.*);
